// ----- src/lxr_pkg.sv -----
// Package: shared types and constants for the combined congruential/xorshift source.
`timescale 1ns / 1ps
package lxr_pkg;

  localparam logic [31:0] LCG_MUL   = 32'd69069;
  localparam logic [31:0] LCG_ADD   = 32'd123;
  localparam logic [31:0] XS_INIT   = 32'd362436069;
  localparam logic [31:0] SEED_INIT = 32'd2282008;
  localparam int unsigned XS_SH_A   = 13;
  localparam int unsigned XS_SH_B   = 17;
  localparam int unsigned XS_SH_C   = 5;

  typedef struct packed {
    logic        [31:0] limit;
    logic signed [31:0] lower_bound;
    logic signed [31:0] upper_bound;
  } lxr_in_t;

  typedef struct packed {
    logic        [31:0] raw_word;
    logic        [31:0] bounded_value;
    logic signed [31:0] ranged_value;
  } lxr_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // take inputs, advance both generator words
    logic sum;       // form raw word and range span
    logic mul_bnd;   // multiply raw word by limit
    logic mul_rng;   // multiply raw word by span magnitude
    logic load_out;  // fill output register
  } lxr_cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SUM  = 5'b00010,
    ST_MULB = 5'b00100,
    ST_MULR = 5'b01000,
    ST_FIN  = 5'b10000
  } lxr_state_t;

endpackage

// ----- src/lcg_xorshift_random_source.sv -----
// Top level: combined congruential/xorshift random source with scaled results.
`timescale 1ns / 1ps
// Each accepted transaction advances a 32-bit congruential word (x = 69069x + 123)
// and a 32-bit xorshift word (13/17/5) once and returns their sum as raw_word,
// plus the bounded value (raw_word*limit)>>32 and the ranged value
// lower_bound + trunc(raw_word*(upper_bound-lower_bound+1)/2^32), wrapped to 32 bits.
// Both words advance on the accepting edge. The sum, two passes through the single
// shared 32x32 multiplier and the output load then follow in order, the load waiting
// while an earlier result is still untaken. In_ready returns the cycle after the output
// load, so a new transaction is taken only once the last one has been loaded.
// The finished result sits in an output register, so the next transaction is
// accepted while it waits to be taken. A write on cfg_we loads the congruential
// word from cfg_wdata and reloads the xorshift word; write it only while idle.
module lcg_xorshift_random_source
  import lxr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  lxr_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output lxr_out_t    out_data
);

  lxr_cmd_t cmd;

  // Sequence the steps and hold the result until taken
  lxr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Generator state, arithmetic and output payload
  lxr_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_data  (out_data)
  );

endmodule

// ----- src/lxr_ctrl.sv -----
// Controller: sequences one transaction through the datapath and owns the output valid.
`timescale 1ns / 1ps
module lxr_ctrl
  import lxr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output lxr_cmd_t cmd
);

  lxr_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_MULB;
      end
      ST_MULB: begin
        cmd.mul_bnd = 1'b1;
        state_nxt   = ST_MULR;
      end
      ST_MULR: begin
        cmd.mul_rng = 1'b1;
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- src/lxr_dpath.sv -----
// Datapath: generator words, shared 32x32 multiplier and output register.
`timescale 1ns / 1ps
module lxr_dpath
  import lxr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  lxr_in_t     in_data,
  input  lxr_cmd_t    cmd,
  output lxr_out_t    out_data
);

  logic [31:0] x_r, y_r, x_nxt, y_nxt;
  logic [31:0] y_t1, y_t2;
  logic [31:0] lim_r, lo_r, hi_r;
  logic [31:0] s_r, bnd_r, q_r;
  logic [32:0] mag_r;
  logic        neg_r;
  logic [33:0] span;
  logic [33:0] span_abs;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [31:0] ranged;
  lxr_out_t    out_r;

  // Generator step
  assign x_nxt = 32'(LCG_MUL * x_r + LCG_ADD);
  assign y_t1  = y_r ^ (y_r << XS_SH_A);
  assign y_t2  = y_t1 ^ (y_t1 >> XS_SH_B);
  assign y_nxt = y_t2 ^ (y_t2 << XS_SH_C);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= SEED_INIT;
      y_r <= XS_INIT;
    end else if (cfg_we) begin
      x_r <= cfg_wdata;
      y_r <= XS_INIT;
    end else if (cmd.capture) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
  end

  // 34-bit signed span; magnitude never exceeds 2^32
  assign span     = {{2{hi_r[31]}}, hi_r} - {{2{lo_r[31]}}, lo_r} + 34'd1;
  assign span_abs = span[33] ? (34'd0 - span) : span;

  assign mul_b = cmd.mul_rng ? mag_r[31:0] : lim_r;
  assign prod  = 64'(s_r) * 64'(mul_b);

  assign ranged = neg_r ? (lo_r - q_r) : (lo_r + q_r);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      lim_r <= in_data.limit;
      lo_r  <= in_data.lower_bound;
      hi_r  <= in_data.upper_bound;
    end
    if (cmd.sum) begin
      s_r   <= x_r + y_r;
      mag_r <= span_abs[32:0];
      neg_r <= span[33];
    end
    if (cmd.mul_bnd) begin
      bnd_r <= prod[63:32];
    end
    if (cmd.mul_rng) begin
      // full span of 2^32 scales by exactly one
      q_r <= mag_r[32] ? s_r : prod[63:32];
    end
    if (cmd.load_out) begin
      out_r.raw_word      <= s_r;
      out_r.bounded_value <= bnd_r;
      out_r.ranged_value  <= ranged;
    end
  end

  assign out_data = out_r;

endmodule

// ----- src/lxr_checker.sv -----
// Checker: port-level assertions for the random source, bound to the top level.
`timescale 1ns / 1ps
module lxr_checker
  import lxr_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input lxr_out_t out_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Busy right after a transaction is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after accept");

  // A new result appears only as the block turns idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result raised while busy");

  // A new result follows a busy period
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised without work");

endmodule

bind lcg_xorshift_random_source lxr_checker u_lxr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- bench/lcg_xorshift_random_source_tb.sv -----
// Testbench for lcg_xorshift_random_source: random draws checked against a local generator model.
`timescale 1ns / 1ps
module lcg_xorshift_random_source_tb;
  import lxr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam logic [31:0] I32_MIN = 32'h8000_0000;
  localparam logic [31:0] I32_MAX = 32'h7FFF_FFFF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  lxr_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  lxr_out_t    out_data;

  // Local copy of both generator words; the seed register only matters through them.
  logic [31:0] lcg_word = SEED_INIT;
  logic [31:0] xs_word = XS_INIT;

  lxr_in_t     draw_requests[$];     // requests waiting to be presented
  lxr_out_t    expected_draws[$];    // predicted results, oldest first
  int unsigned issued_total = 0;
  int unsigned accepted_total = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int          send_gap = 0;
  int          take_gap = 0;
  bit          steady = 1'b0;        // no idling on either side in the final stretch

  lcg_xorshift_random_source dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // Advance both generator words once and scale their sum the way the block does.
  function automatic lxr_out_t next_draw(lxr_in_t req);
    lxr_out_t          res;
    logic [31:0]       y;
    logic [31:0]       s;
    logic signed [33:0] span;
    logic [33:0]       mag;
    logic [63:0]       prod;
    lcg_word = lcg_word * LCG_MUL + LCG_ADD;
    y = xs_word;
    y = y ^ (y << XS_SH_A);
    y = y ^ (y >> XS_SH_B);
    y = y ^ (y << XS_SH_C);
    xs_word = y;
    s = lcg_word + xs_word;
    res.raw_word = s;
    prod = 64'(s) * 64'(req.limit);
    res.bounded_value = prod[63:32];
    // Exact 34-bit span; its sign decides whether the scaled part is added or taken off.
    span = {{2{req.upper_bound[31]}}, req.upper_bound}
         - {{2{req.lower_bound[31]}}, req.lower_bound} + 34'sd1;
    mag = span[33] ? (~span + 34'd1) : span;
    prod = 64'(s) * 64'(mag);
    if (span[33]) begin
      res.ranged_value = req.lower_bound - prod[63:32];
    end else begin
      res.ranged_value = req.lower_bound + prod[63:32];
    end
    return res;
  endfunction

  // Driver: present queued requests, hold each one until it is taken, idle in bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_draws.push_back(next_draw(in_data));
        accepted_total++;
      end
      if (!in_valid || in_ready) begin
        // Slot is free: idle, load the next request, or drop valid.
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (draw_requests.size() > 0) begin
          if (!steady && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 13) - 1;
            in_valid <= 1'b0;
          end else begin
            in_data  <= draw_requests.pop_front();
            in_valid <= 1'b1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest prediction; stall in bursts.
  always @(posedge clk) begin
    lxr_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_draws.size() == 0) begin
          $display("%0t: unexpected result raw=%h bounded=%h ranged=%h", $time,
                   out_data.raw_word, out_data.bounded_value, out_data.ranged_value);
          error_count++;
        end else begin
          want = expected_draws.pop_front();
          if (out_data.raw_word !== want.raw_word) begin
            $display("%0t: raw_word expected %h actual %h", $time,
                     want.raw_word, out_data.raw_word);
            error_count++;
          end
          if (out_data.bounded_value !== want.bounded_value) begin
            $display("%0t: bounded_value expected %h actual %h", $time,
                     want.bounded_value, out_data.bounded_value);
            error_count++;
          end
          if (out_data.ranged_value !== want.ranged_value) begin
            $display("%0t: ranged_value expected %h actual %h", $time,
                     want.ranged_value, out_data.ranged_value);
            error_count++;
          end
        end
      end
      if (take_gap > 0) begin
        take_gap--;
        out_ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 7) == 0) begin
        take_gap = $urandom_range(1, 13) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic add_request(logic [31:0] lim, logic [31:0] lo, logic [31:0] hi);
    lxr_in_t r;
    r.limit = lim;
    r.lower_bound = lo;
    r.upper_bound = hi;
    draw_requests.push_back(r);
    issued_total++;
  endtask

  // Mostly well-formed ranges of assorted widths; some reversed, empty or wide ones.
  task automatic add_random_requests(int unsigned count);
    logic [31:0]  lim;
    logic [31:0]  lo;
    logic [31:0]  hi;
    int unsigned  pick;
    repeat (count) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0:       lim = '0;
        1:       lim = '1;
        2, 3:    lim = $urandom_range(1, 64);
        default: lim = $urandom;
      endcase
      lo = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        hi = lo + $urandom_range(0, 1000);
      end else if (pick < 55) begin
        hi = lo + ($urandom >> $urandom_range(0, 31));
      end else if (pick < 70) begin
        hi = lo - $urandom_range(1, 1000);
      end else if (pick < 80) begin
        lo = I32_MIN + $urandom_range(0, 3);
        hi = I32_MAX - $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) begin
          {lo, hi} = {hi, lo};
        end
      end else if (pick < 90) begin
        hi = $urandom_range(0, 1) ? lo : lo - 1;
      end else begin
        hi = $urandom;
      end
      add_request(lim, lo, hi);
    end
  endtask

  // Hold off the sender until every queued transaction has been taken and answered.
  task automatic drain();
    while (accepted_total != issued_total || expected_draws.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Write the seed only with the block quiet; the xorshift word restarts as well.
  task automatic load_seed(logic [31:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    lcg_word = value;
    xs_word  = XS_INIT;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: run from the reset seed through limit and bound extremes.
    add_request('0,            32'd0,         32'd0);           // zero limit, single value
    add_request('1,            I32_MIN,       I32_MAX);         // full range
    add_request(32'd1,         I32_MAX,       I32_MIN);         // most reversed bounds
    add_request(32'h8000_0000, 32'd5,         32'd4);           // empty span
    add_request(32'd2,         '1,            '1);
    add_request(32'd10,        -32'sd100,     32'd100);
    add_request(32'd7,         32'd100,       -32'sd100);       // reversed around zero
    add_request('1,            I32_MAX,       I32_MAX);
    add_request('0,            I32_MIN,       I32_MIN);
    add_request(32'd1000,      I32_MIN + 1,   I32_MAX);
    add_request(32'd3,         I32_MIN,       I32_MAX - 1);
    add_request(32'd64,        32'd0,         '1);              // empty span across zero
    add_request(32'd5,         '1,            32'd0);
    add_request(32'h7FFF_FFFF, 32'd0,         I32_MIN);
    add_request(32'd3,         I32_MIN,       '1);
    add_request(32'hFFFF_FFFE, 32'd1,         I32_MAX);
    add_request(32'h5555_5555, I32_MAX,       32'd0);
    add_request(32'hAAAA_AAAA, I32_MAX - 1,   I32_MIN + 1);
    drain();

    load_seed('0);
    add_random_requests(300);
    load_seed('1);
    add_random_requests(300);
    drain();                                      // pause without a seed change
    add_random_requests(300);
    load_seed($urandom);
    steady = 1'b1;
    add_random_requests(300);
    drain();

    // Catch any stray result before deciding.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/lxr_pkg.sv
src/lxr_ctrl.sv
src/lxr_dpath.sv
src/lcg_xorshift_random_source.sv
src/lxr_checker.sv
bench/lcg_xorshift_random_source_tb.sv
